/* rtl/scsf_pkg.sv */
// Package for the source comment and space filter.
// Holds the shared constants, the comment mode encoding and the transfer plan type.
// Depends on nothing; every other file in rtl but scsf_ram imports it.
package scsf_pkg;

    localparam int PENDING_DEPTH = 32;
    localparam int PEND_AW       = $clog2(PENDING_DEPTH);
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef logic [1:0] ws_code_t;

    localparam ws_code_t WS_SPACE = 2'd0;
    localparam ws_code_t WS_TAB   = 2'd1;
    localparam ws_code_t WS_CR    = 2'd2;

    typedef enum logic [4:0] {
        MODE_NORMAL = 5'b00001,
        MODE_SLASH  = 5'b00010,
        MODE_LINE   = 5'b00100,
        MODE_BLOCK  = 5'b01000,
        MODE_STAR   = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       valid;
        logic       has;
        logic [7:0] data;
    } tail_t;

    typedef struct packed {
        logic [CNT_W-1:0] flush_cnt;
        tail_t            t0;
        tail_t            t1;
        logic             done;
        logic             trunc;
    } plan_t;

    function automatic logic [7:0] ws_char(input ws_code_t code);
        logic [7:0] ch;
        case (code)
            WS_TAB:  ch = CH_TAB;
            WS_CR:   ch = CH_CR;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/source_comment_and_space_filter_unit.sv */
// Source comment and space filter: strips // and /* */ comments from a byte stream,
// trims and collapses whitespace per line and drops empty lines.
// Depends on scsf_pkg, scsf_ram, scsf_ctrl and scsf_emit.
//
// A byte that produces no output leaves the emitter idle, so such bytes stream at one
// per cycle while no result is pending. A byte that produces output blocks new input
// until its last result has entered the output register; whitespace held back inside
// a line is replayed from the pending RAM at one entry per cycle while the output is
// free, which bounds a burst at 34 results. The input accepts the next transfer while
// the final result still waits in the output register. Whitespace beyond 32 pending
// entries is dropped and marked on run_truncated until the end of the text.
module source_comment_and_space_filter_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // last
    output logic [2:0] m_tuser    // has_byte, done_res, run_truncated
);
    import scsf_pkg::*;

    logic               accept;
    logic               ready;
    plan_t              plan;
    logic               wr_en;
    logic [PEND_AW-1:0] wr_addr;
    ws_code_t           wr_data;
    logic               rd_en;
    logic [PEND_AW-1:0] rd_addr;
    ws_code_t           rd_data;

    assign s_tready = ready;
    assign accept   = s_tvalid && ready;

    scsf_ram #(
        .WIDTH ($bits(ws_code_t)),
        .DEPTH (PENDING_DEPTH)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    scsf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (s_tdata),
        .end_of_text (s_tlast),
        .plan        (plan),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    scsf_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .plan     (plan),
        .ready    (ready),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/scsf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// A read and a write of the same address in one cycle return the old data.
// Depends on nothing.
module scsf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/scsf_ctrl.sv */
// Line and comment tracker: decodes each accepted byte against the comment mode,
// pushes whitespace into the pending RAM and hands the emitter a transfer plan.
// Depends on scsf_pkg.
module scsf_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    in_byte,
    input  logic                          end_of_text,
    output scsf_pkg::plan_t               plan,
    output logic                          wr_en,
    output logic [scsf_pkg::PEND_AW-1:0]  wr_addr,
    output scsf_pkg::ws_code_t            wr_data
);
    import scsf_pkg::*;

    mode_t            mode_reg, mode_next;
    logic             lhc_reg, lhc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             lsp_reg, lsp_next;
    logic             trunc_reg, trunc_next;

    logic             slash_emit;
    logic             lhc_e;
    logic [CNT_W-1:0] cnt_e;
    mode_t            mode_e;
    logic             line_end;
    logic             is_ws;
    ws_code_t         code;
    logic             push_en;

    always_comb
    begin
        slash_emit = (mode_reg == MODE_SLASH) &&
                     (end_of_text || (in_byte != CH_SLASH && in_byte != CH_STAR));
        lhc_e      = slash_emit | lhc_reg;
        cnt_e      = slash_emit ? '0 : cnt_reg;
        mode_e     = slash_emit ? MODE_NORMAL : mode_reg;
        line_end   = 1'b0;
        push_en    = 1'b0;
        is_ws      = (in_byte == CH_SPACE) || (in_byte == CH_TAB) || (in_byte == CH_CR);
        code       = (in_byte == CH_TAB) ? WS_TAB : ((in_byte == CH_CR) ? WS_CR : WS_SPACE);

        mode_next  = mode_reg;
        lhc_next   = lhc_reg;
        cnt_next   = cnt_reg;
        lsp_next   = lsp_reg;
        trunc_next = trunc_reg;

        plan       = '0;
        plan.trunc = trunc_reg;

        if (slash_emit)
        begin
            plan.flush_cnt = cnt_reg;
            plan.t0        = '{valid: 1'b1, has: 1'b1, data: CH_SLASH};
        end

        if (end_of_text)
        begin
            plan.done = 1'b1;
            if (lhc_e)
            begin
                plan.t1 = '{valid: 1'b1, has: 1'b1, data: CH_LF};
            end
            else
            begin
                plan.t1 = '{valid: 1'b1, has: 1'b0, data: 8'h00};
            end
            mode_next  = MODE_NORMAL;
            lhc_next   = 1'b0;
            cnt_next   = '0;
            lsp_next   = 1'b0;
            trunc_next = 1'b0;
        end
        else if (mode_reg == MODE_SLASH && in_byte == CH_SLASH)
        begin
            mode_next = MODE_LINE;
        end
        else if (mode_reg == MODE_SLASH && in_byte == CH_STAR)
        begin
            mode_next = MODE_BLOCK;
        end
        else
        begin
            mode_next = mode_e;
            lhc_next  = lhc_e;
            cnt_next  = cnt_e;
            unique case (mode_e)
                MODE_NORMAL:
                begin
                    if (in_byte == CH_LF)
                    begin
                        line_end = 1'b1;
                    end
                    else if (in_byte == CH_SLASH)
                    begin
                        mode_next = MODE_SLASH;
                    end
                    else if (is_ws)
                    begin
                        if (lhc_e && !(code == WS_SPACE && cnt_e != '0 && lsp_reg))
                        begin
                            if (cnt_e >= CNT_W'(PENDING_DEPTH))
                            begin
                                trunc_next = 1'b1;
                            end
                            else
                            begin
                                push_en  = 1'b1;
                                cnt_next = cnt_e + 1'b1;
                                lsp_next = (code == WS_SPACE);
                            end
                        end
                    end
                    else
                    begin
                        plan.flush_cnt = cnt_reg;
                        plan.t1        = '{valid: 1'b1, has: 1'b1, data: in_byte};
                        lhc_next       = 1'b1;
                        cnt_next       = '0;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_LF)
                    begin
                        line_end  = 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (in_byte == CH_STAR)
                    begin
                        mode_next = MODE_STAR;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        line_end = 1'b1;
                    end
                end
                MODE_STAR:
                begin
                    if (in_byte == CH_SLASH)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (in_byte != CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                        line_end  = (in_byte == CH_LF);
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase

            if (line_end)
            begin
                cnt_next = '0;
                lhc_next = 1'b0;
                if (lhc_e)
                begin
                    plan.t1 = '{valid: 1'b1, has: 1'b1, data: CH_LF};
                end
            end
        end

        wr_en   = accept && push_en;
        wr_addr = cnt_e[PEND_AW-1:0];
        wr_data = code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            lhc_reg   <= 1'b0;
            cnt_reg   <= '0;
            lsp_reg   <= 1'b0;
            trunc_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            lhc_reg   <= lhc_next;
            cnt_reg   <= cnt_next;
            lsp_reg   <= lsp_next;
            trunc_reg <= trunc_next;
        end
    end

endmodule

/* rtl/scsf_emit.sv */
// Result emitter: replays the pending whitespace from the RAM one entry per cycle,
// then the held slash and the closing byte, into the output register while it is free.
// Depends on scsf_pkg.
module scsf_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  scsf_pkg::plan_t               plan,
    output logic                          ready,
    output logic                          rd_en,
    output logic [scsf_pkg::PEND_AW-1:0]  rd_addr,
    input  scsf_pkg::ws_code_t            rd_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // out_byte
    output logic                          m_tlast,   // last
    output logic [2:0]                    m_tuser    // has_byte, done_res, run_truncated
);
    import scsf_pkg::*;

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_FLUSH = 3'b010,
        E_TAIL  = 3'b100
    } emit_state_t;

    emit_state_t        state_reg, state_next;
    logic [PEND_AW-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    tail_t              t0_reg, t0_next;
    tail_t              t1_reg, t1_next;
    logic               done_reg, done_next;
    logic               trunc_reg, trunc_next;

    logic               mv_reg, mv_next;
    logic [7:0]         mdata_reg, mdata_next;
    logic               mlast_reg, mlast_next;
    logic [2:0]         muser_reg, muser_next;

    logic               out_free;
    logic               last_entry;
    logic               fin;
    tail_t              sel;

    always_comb
    begin
        out_free   = !mv_reg || m_tready;
        last_entry = ((CNT_W'(ptr_reg) + 1'b1) == cnt_reg);
        fin        = 1'b0;
        sel        = t0_reg.valid ? t0_reg : t1_reg;

        state_next = state_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        done_next  = done_reg;
        trunc_next = trunc_reg;

        mv_next    = mv_reg && !m_tready;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;
        muser_next = muser_reg;

        rd_en      = 1'b0;
        rd_addr    = ptr_reg + 1'b1;

        unique case (state_reg)
            E_IDLE:
            begin
                if (accept)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    ptr_next   = '0;
                    cnt_next   = plan.flush_cnt;
                    t0_next    = plan.t0;
                    t1_next    = plan.t1;
                    done_next  = plan.done;
                    trunc_next = plan.trunc;
                    if (plan.flush_cnt != '0)
                    begin
                        state_next = E_FLUSH;
                    end
                    else if (plan.t0.valid || plan.t1.valid)
                    begin
                        state_next = E_TAIL;
                    end
                end
            end
            E_FLUSH:
            begin
                if (out_free)
                begin
                    fin        = last_entry && !t0_reg.valid && !t1_reg.valid;
                    mv_next    = 1'b1;
                    mdata_next = ws_char(rd_data);
                    mlast_next = fin;
                    muser_next = {trunc_reg, done_reg && fin, 1'b1};
                    if (last_entry)
                    begin
                        state_next = fin ? E_IDLE : E_TAIL;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            E_TAIL:
            begin
                if (out_free)
                begin
                    fin        = !(t0_reg.valid && t1_reg.valid);
                    mv_next    = 1'b1;
                    mdata_next = sel.data;
                    mlast_next = fin;
                    muser_next = {trunc_reg, done_reg && fin, sel.has};
                    if (t0_reg.valid)
                    begin
                        t0_next.valid = 1'b0;
                    end
                    else
                    begin
                        t1_next.valid = 1'b0;
                    end
                    if (fin)
                    begin
                        state_next = E_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        cnt_reg   <= cnt_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        done_reg  <= done_next;
        trunc_reg <= trunc_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

    assign ready    = (state_reg == E_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

endmodule

/* tb/tb.sv */
// Testbench for source_comment_and_space_filter_unit: streams directed and random source
// text, predicts every filtered byte in a behavioral model and checks each output transfer.
// Depends on scsf_pkg and the RTL of the filter unit.
module tb;
    import scsf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       done;
        logic       trunc;
    } text_out_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [2:0] m_tuser;

    text_out_t  filtered_text[$];
    text_out_t  item_out[$];

    mode_t      cmode;
    logic       line_open;
    ws_code_t   pend_ws[PENDING_DEPTH];
    int         pend_cnt;
    logic       trunc_flag;

    int         send_idle_pct;
    int         recv_idle_pct;
    int         sent_items;
    int         mismatches;
    int         cycle_count;

    source_comment_and_space_filter_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void clear_state();
        cmode      = MODE_NORMAL;
        line_open  = 1'b0;
        pend_cnt   = 0;
        trunc_flag = 1'b0;
    endfunction

    function automatic void put_out(input logic [7:0] b, input logic has);
        text_out_t r;
        r.data  = b;
        r.has   = has;
        r.last  = 1'b0;
        r.done  = 1'b0;
        r.trunc = trunc_flag;
        item_out = {item_out, r};
    endfunction

    function automatic void emit_content(input logic [7:0] b);
        logic [7:0] ch;
        for (int i = 0; i < pend_cnt; i++)
        begin
            case (pend_ws[i])
                WS_TAB:  ch = CH_TAB;
                WS_CR:   ch = CH_CR;
                default: ch = CH_SPACE;
            endcase
            put_out(ch, 1'b1);
        end
        pend_cnt = 0;
        put_out(b, 1'b1);
        line_open = 1'b1;
    endfunction

    function automatic void hold_ws(input ws_code_t code);
        if (!line_open)
            return;
        if (code == WS_SPACE && pend_cnt > 0 && pend_ws[pend_cnt - 1] == WS_SPACE)
            return;
        if (pend_cnt >= PENDING_DEPTH)
        begin
            trunc_flag = 1'b1;
            return;
        end
        pend_ws[pend_cnt] = code;
        pend_cnt++;
    endfunction

    function automatic void end_line();
        pend_cnt = 0;
        if (line_open)
            put_out(CH_LF, 1'b1);
        line_open = 1'b0;
    endfunction

    function automatic void strip_and_trim(input logic [7:0] b, input logic eot);
        logic      taken;
        text_out_t r;
        item_out.delete();
        taken = 1'b0;
        if (eot)
        begin
            if (cmode == MODE_SLASH)
                emit_content(CH_SLASH);
            if (line_open)
                put_out(CH_LF, 1'b1);
            if (item_out.size() == 0)
                put_out(8'h00, 1'b0);
            clear_state();
        end
        else
        begin
            if (cmode == MODE_SLASH)
            begin
                if (b == CH_SLASH)
                begin
                    cmode = MODE_LINE;
                    taken = 1'b1;
                end
                else if (b == CH_STAR)
                begin
                    cmode = MODE_BLOCK;
                    taken = 1'b1;
                end
                else
                begin
                    emit_content(CH_SLASH);
                    cmode = MODE_NORMAL;
                end
            end
            if (!taken)
            begin
                case (cmode)
                    MODE_NORMAL:
                    begin
                        if (b == CH_LF)
                            end_line();
                        else if (b == CH_SLASH)
                            cmode = MODE_SLASH;
                        else if (b == CH_SPACE)
                            hold_ws(WS_SPACE);
                        else if (b == CH_TAB)
                            hold_ws(WS_TAB);
                        else if (b == CH_CR)
                            hold_ws(WS_CR);
                        else
                            emit_content(b);
                    end
                    MODE_LINE:
                    begin
                        if (b == CH_LF)
                        begin
                            end_line();
                            cmode = MODE_NORMAL;
                        end
                    end
                    MODE_BLOCK:
                    begin
                        if (b == CH_STAR)
                            cmode = MODE_STAR;
                        else if (b == CH_LF)
                            end_line();
                    end
                    default:
                    begin
                        if (b == CH_SLASH)
                            cmode = MODE_NORMAL;
                        else if (b == CH_STAR)
                            cmode = MODE_STAR;
                        else
                        begin
                            cmode = MODE_BLOCK;
                            if (b == CH_LF)
                                end_line();
                        end
                    end
                endcase
            end
        end
        for (int i = 0; i < item_out.size(); i++)
        begin
            r = item_out[i];
            if (i == item_out.size() - 1)
            begin
                r.last = 1'b1;
                r.done = eot;
            end
            filtered_text = {filtered_text, r};
        end
    endfunction

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        text_out_t got;
        text_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1], m_tuser[2]};
            if (filtered_text.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected transfer: data=%h has=%b last=%b done=%b trunc=%b",
                             got.data, got.has, got.last, got.done, got.trunc);
            end
            else
            begin
                want = filtered_text.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"Mismatch: expected data=%h has=%b last=%b done=%b trunc=%b,",
                                  " got data=%h has=%b last=%b done=%b trunc=%b"},
                                 want.data, want.has, want.last, want.done, want.trunc,
                                 got.data, got.has, got.last, got.done, got.trunc);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("source_comment_and_space_filter_unit test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        do
            @(posedge clk);
        while (!s_tready);
        strip_and_trim(b, eot);
        sent_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        if ($urandom_range(3) != 0)
            return 8'h61 + 8'($urandom_range(25));
        do
            c = 8'($urandom_range(255));
        while (c inside {CH_SLASH, CH_STAR, CH_LF, CH_SPACE, CH_TAB, CH_CR});
        return c;
    endfunction

    function automatic logic [7:0] ws_byte();
        case ($urandom_range(2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    task automatic send_token();
        int         n;
        logic [7:0] pick[6];
        pick = '{CH_STAR, CH_SLASH, CH_LF, CH_SPACE, 8'h61, CH_STAR};
        case ($urandom_range(19))
            0, 1, 2, 3, 17, 18:
            begin
                n = $urandom_range(1, 5);
                repeat (n) send_item(plain_byte(), 1'b0);
            end
            4, 5:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_item(CH_SPACE, 1'b0);
            end
            6, 7:
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(ws_byte(), 1'b0);
            end
            8, 9:
                send_item(CH_LF, 1'b0);
            10:
            begin
                send_text("//");
                n = $urandom_range(0, 4);
                repeat (n) send_item($urandom_range(1) ? plain_byte() : pick[$urandom_range(5)],
                                     1'b0);
                if ($urandom_range(4) != 0)
                    send_item(CH_LF, 1'b0);
            end
            11:
            begin
                send_text("/*");
                n = $urandom_range(0, 5);
                repeat (n) send_item(pick[$urandom_range(5)], 1'b0);
                if ($urandom_range(4) != 0)
                    send_text("*/");
            end
            12:
            begin
                send_item(CH_SLASH, 1'b0);
                send_item(plain_byte(), 1'b0);
            end
            13:
            begin
                send_item(CH_SLASH, 1'b0);
                send_item(ws_byte(), 1'b0);
            end
            14:
                send_item(8'($urandom_range(255)), 1'b0);
            15:
            begin
                if ($urandom_range(5) == 0)
                begin
                    n = $urandom_range(30, 38);
                    repeat (n) send_item($urandom_range(1) ? CH_TAB : ws_byte(), 1'b0);
                end
                else
                    send_item(CH_SLASH, 1'b0);
            end
            16:
                send_end();
            default:
                send_item(plain_byte(), 1'b0);
        endcase
    endtask

    task automatic test_empty_text();
        send_end();
    endtask

    task automatic test_comments_and_spacing();
        send_text("\ta  \t\015 /x/*/ *\n*/");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("//c\n/");
        send_end();
    endtask

    task automatic test_open_comment_at_end();
        send_text("/*");
        send_end();
    endtask

    task automatic test_long_whitespace_run();
        int n;
        n = $urandom_range(34, 40);
        send_item(plain_byte(), 1'b0);
        repeat (n) send_item($urandom_range(3) != 0 ? CH_TAB : CH_CR, 1'b0);
        send_item(plain_byte(), 1'b0);
        send_item(CH_LF, 1'b0);
        send_end();
    endtask

    task automatic test_drain_pause();
        s_tvalid <= 1'b0;
        while (filtered_text.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_random_text(input int count, input int send_pct, input int recv_pct);
        int stop_at;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
            send_token();
        send_end();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= 8'h00;
        s_tlast       <= 1'b0;
        sent_items    = 0;
        mismatches    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 49;
        clear_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_text();
        test_comments_and_spacing();
        test_open_comment_at_end();
        test_drain_pause();
        test_long_whitespace_run();
        test_random_text(50, 11, 49);
        test_drain_pause();
        test_random_text(50, 11, 49);
        test_random_text(100, 49, 11);
        test_random_text(100, 0, 0);

        s_tvalid <= 1'b0;
        while (filtered_text.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && filtered_text.size() == 0)
            $display("source_comment_and_space_filter_unit test passed");
        else
            $display("source_comment_and_space_filter_unit test failed");
        $finish;
    end
endmodule
